[rtl/depq_pkg.sv]
package depq_pkg;

  // Request opcodes
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_POP_HI  = 2'd1;
  localparam logic [1:0] OP_POP_LO  = 2'd2;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned CLIENT_W = 24;
  localparam int unsigned COUNT_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Contents of one cell of the ordered row
  typedef struct packed {
    logic                       valid;
    logic signed [KEY_W-1:0]    key;
    logic [CLIENT_W-1:0]        client;
    logic [COUNT_W-1:0]         count;
  } entry_t;

  // Request and global flags broadcast to every cell
  typedef struct packed {
    logic [1:0]                 op;
    logic signed [KEY_W-1:0]    key;
    logic [CLIENT_W-1:0]        client;
    logic                       cmp_en;
    logic                       apply_en;
    logic                       any_match;
    logic                       full;
    logic                       low_shift;
  } cmd_t;

endpackage

[rtl/depq_cell.sv]
module depq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  depq_pkg::cmd_t   cmd_i,
  input  depq_pkg::entry_t left_i,     // neighbor holding the next smaller key
  input  depq_pkg::entry_t right_i,    // neighbor holding the next larger key
  input  logic            left_ge_i,  // left neighbor is empty or holds a key above the new key
  output depq_pkg::entry_t ent_o,
  output logic            ge_o,
  output logic            match_o
);

  logic                              valid_q, valid_d;
  logic signed [depq_pkg::KEY_W-1:0] key_q, key_d;
  logic [depq_pkg::CLIENT_W-1:0]     client_q, client_d;
  logic [depq_pkg::COUNT_W-1:0]      count_q, count_d;
  logic                              ge_q, match_q;
  logic                              is_top, is_bottom;

  assign ent_o   = '{valid: valid_q, key: key_q, client: client_q, count: count_q};
  assign ge_o    = ge_q;
  assign match_o = match_q;

  // Row is packed from cell 0 upward, so ends are found from the neighbors
  assign is_top    = valid_q && !right_i.valid;
  assign is_bottom = valid_q && !left_i.valid;

  // Next contents of the cell
  always_comb begin
    valid_d  = valid_q;
    key_d    = key_q;
    client_d = client_q;
    count_d  = count_q;
    if (cmd_i.apply_en) begin
      case (cmd_i.op)
        depq_pkg::OP_INSERT: begin
          if (cmd_i.any_match) begin
            if (match_q && count_q != depq_pkg::COUNT_MAX) begin
              count_d = count_q + {{(depq_pkg::COUNT_W-1){1'b0}}, 1'b1};
            end
          end else if (!cmd_i.full) begin
            if (left_ge_i) begin
              // shift up to make room below
              valid_d  = left_i.valid;
              key_d    = left_i.key;
              client_d = left_i.client;
              count_d  = left_i.count;
            end else if (ge_q) begin
              valid_d  = 1'b1;
              key_d    = cmd_i.key;
              client_d = cmd_i.client;
              count_d  = {{(depq_pkg::COUNT_W-1){1'b0}}, 1'b1};
            end
          end
        end
        depq_pkg::OP_POP_HI: begin
          if (is_top) begin
            if (count_q > {{(depq_pkg::COUNT_W-1){1'b0}}, 1'b1}) begin
              count_d = count_q - {{(depq_pkg::COUNT_W-1){1'b0}}, 1'b1};
            end else begin
              valid_d = 1'b0;
            end
          end
        end
        depq_pkg::OP_POP_LO: begin
          if (cmd_i.low_shift) begin
            // lowest entry leaves, row shifts down
            valid_d  = right_i.valid;
            key_d    = right_i.key;
            client_d = right_i.client;
            count_d  = right_i.count;
          end else if (is_bottom) begin
            count_d = count_q - {{(depq_pkg::COUNT_W-1){1'b0}}, 1'b1};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload and compare flags
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    client_q <= client_d;
    count_q  <= count_d;
    if (cmd_i.cmp_en) begin
      ge_q    <= !valid_q || (key_q > cmd_i.key);
      match_q <= valid_q && (key_q == cmd_i.key);
    end
  end

endmodule

[rtl/double_ended_priority_queue.sv]
// Double-ended priority queue of (key, client) entries held in a sorted
// row of CAPACITY cells, smallest key in cell 0.
// Input channel s_axis: one request per handshake (insert, pop highest,
// pop lowest). Output channel m_axis: exactly one result per request,
// carrying the served client, a found flag and a dropped flag.
// Each request passes a compare state, in which every cell compares its
// key with the request key, and then an update state, in which cells shift
// or count up/down and the result register loads.
// A new request can be taken in the update state, while the previous one
// is still being applied in the cell row.
// If the receiver stalls, the result waits in the output register; one
// more request can then be taken and held in its update cycle until the
// output register frees, while s_axis_tready_o stays low.
// Reset clears all cell valid bits (empty queue) and the output valid; no
// clearing pass is needed.
module double_ended_priority_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // opcode[1:0], prio_key[33:2], client_id[57:34]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // served_client[23:0], found[24], dropped[25]
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]                         state_q, state_d;
  logic [1:0]                         op_q;
  logic signed [depq_pkg::KEY_W-1:0]  key_q;
  logic [depq_pkg::CLIENT_W-1:0]      client_q;
  logic                               m_valid_q, m_valid_d;
  logic [31:0]                        m_data_q;
  logic [31:0]                        m_data_d;

  depq_pkg::cmd_t                     cmd;
  depq_pkg::entry_t                   ent   [CAPACITY];
  logic [CAPACITY-1:0]                ge_vec, match_vec;
  logic                               accept, out_free, do_apply;
  logic [depq_pkg::CLIENT_W-1:0]      top_client;
  logic [depq_pkg::CLIENT_W-1:0]      served;
  logic                               found, dropped;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign do_apply        = (state_q == ST_APPLY) && out_free;
  assign s_axis_tready_o = (state_q == ST_IDLE) || do_apply;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Broadcast request to the cell row
  always_comb begin
    cmd.op        = op_q;
    cmd.key       = key_q;
    cmd.client    = client_q;
    cmd.cmp_en    = (state_q == ST_CMP);
    cmd.apply_en  = do_apply;
    cmd.any_match = |match_vec;
    cmd.full      = ent[CAPACITY-1].valid;
    cmd.low_shift = ent[0].valid && (ent[0].count == {{(depq_pkg::COUNT_W-1){1'b0}}, 1'b1});
  end

  // Cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    depq_pkg::entry_t left_ent, right_ent;
    logic             left_ge;
    if (g == 0) begin : g_first
      assign left_ent = '0;
      assign left_ge  = 1'b0;
    end else begin : g_inner_l
      assign left_ent = ent[g-1];
      assign left_ge  = ge_vec[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner_r
      assign right_ent = ent[g+1];
    end
    depq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    (left_ent),
      .right_i   (right_ent),
      .left_ge_i (left_ge),
      .ent_o     (ent[g]),
      .ge_o      (ge_vec[g]),
      .match_o   (match_vec[g])
    );
  end

  // Client of the highest valid cell
  always_comb begin
    top_client = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ent[i].valid && (i == CAPACITY - 1 || !ent[(i + 1) % CAPACITY].valid)) begin
        top_client = top_client | ent[i].client;
      end
    end
  end

  // Result fields
  always_comb begin
    served  = '0;
    found   = 1'b0;
    dropped = 1'b0;
    case (op_q)
      depq_pkg::OP_INSERT: begin
        dropped = !cmd.any_match && cmd.full;
      end
      depq_pkg::OP_POP_HI: begin
        found  = ent[0].valid;
        served = top_client;
      end
      depq_pkg::OP_POP_LO: begin
        found  = ent[0].valid;
        served = ent[0].valid ? ent[0].client : '0;
      end
      default: begin
      end
    endcase
    m_data_d = {6'd0, dropped, found, served};
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q;
    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (do_apply) begin
          m_valid_d = 1'b1;
          state_d   = accept ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= s_axis_tdata_i[1:0];
      key_q    <= s_axis_tdata_i[33:2];
      client_q <= s_axis_tdata_i[57:34];
    end
    if (do_apply) begin
      m_data_q <= m_data_d;
    end
  end

endmodule
